// ----- src/qte_pkg.sv -----
// ----------------------------------------------------------------------------
// qte_pkg
// shared widths, constants and the arctangent table for quaternion_to_euler
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int SUM_W         = 35;
    localparam int CW            = 38;
    localparam int RAD_W         = 62;
    localparam int ROOT_W        = 31;
    localparam int SINP_W        = 31;
    localparam int MAG_W         = 30;

    localparam logic signed [SUM_W-1:0] ONE_Q30 = SUM_W'(64'sd1073741824);
    localparam logic [RAD_W-1:0]        ONE_Q60 = RAD_W'(64'd1) << 60;
    localparam logic [15:0]             PITCH_POS = 16'h4000;
    localparam logic [15:0]             PITCH_NEG = 16'hC000;
    localparam logic [31:0]             ACC_PI    = 32'h8000_0000;
    localparam logic [31:0]             ROUND_HALF = 32'h0000_8000;

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic                     pole_pos;
        logic                     pole_neg;
        logic signed [SINP_W-1:0] sinp;
    } t_ptag;

endpackage

// ----- src/qte_sqrt.sv -----
// ----------------------------------------------------------------------------
// qte_sqrt
// pipelined floor square root, one root bit per stage, tag carried alongside
// ----------------------------------------------------------------------------
module qte_sqrt (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [qte_pkg::RAD_W-1:0]       i_rad,
    input  qte_pkg::t_ptag                  i_tag,
    output logic [qte_pkg::ROOT_W-1:0]      o_root,
    output qte_pkg::t_ptag                  o_tag
);
    import qte_pkg::*;

    logic [RAD_W-1:0]  r_rem [ROOT_W];
    logic [ROOT_W-1:0] r_q   [ROOT_W];
    t_ptag             r_tag [ROOT_W];

    for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
        localparam int K = ROOT_W - 1 - s;
        logic [RAD_W-1:0]  p_rem;
        logic [ROOT_W-1:0] p_q;
        t_ptag             p_tag;
        logic [RAD_W-1:0]  trial;

        if (s == 0) begin : g_first
            assign p_rem = i_rad;
            assign p_q   = '0;
            assign p_tag = i_tag;
        end else begin : g_next
            assign p_rem = r_rem[s-1];
            assign p_q   = r_q[s-1];
            assign p_tag = r_tag[s-1];
        end

        assign trial = (RAD_W'(p_q) << (K + 1)) + (RAD_W'(1) << (2 * K));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[s] <= p_tag;
                if (p_rem >= trial) begin
                    r_rem[s] <= p_rem - trial;
                    r_q[s]   <= p_q | (ROOT_W'(1) << K);
                end else begin
                    r_rem[s] <= p_rem;
                    r_q[s]   <= p_q;
                end
            end
        end
    end

    assign o_root = r_q[ROOT_W-1];
    assign o_tag  = r_tag[ROOT_W-1];

endmodule

// ----- src/qte_cordic.sv -----
// ----------------------------------------------------------------------------
// qte_cordic
// pipelined vectoring cordic atan2, quadrant fold then one stage per iteration
// ----------------------------------------------------------------------------
module qte_cordic (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [qte_pkg::CW-1:0]   i_y,
    input  logic signed [qte_pkg::CW-1:0]   i_x,
    output logic [15:0]                     o_angle
);
    import qte_pkg::*;

    logic signed [CW-1:0] r_x    [CORDIC_STAGES+1];
    logic signed [CW-1:0] r_y    [CORDIC_STAGES+1];
    logic [31:0]          r_acc  [CORDIC_STAGES+1];
    logic                 r_zero [CORDIC_STAGES+1];
    logic [31:0]          rounded;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x[CW-1]) begin
                r_x[0]   <= -i_x;
                r_y[0]   <= -i_y;
                r_acc[0] <= ACC_PI;
            end else begin
                r_x[0]   <= i_x;
                r_y[0]   <= i_y;
                r_acc[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
        localparam logic [31:0] T = (i < 32) ? ATAN_TAB[i % 32] : 32'h0;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[i+1] <= r_zero[i];
                if (!r_y[i][CW-1]) begin
                    r_x[i+1]   <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1]   <= r_y[i] - (r_x[i] >>> i);
                    r_acc[i+1] <= r_acc[i] + T;
                end else begin
                    r_x[i+1]   <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1]   <= r_y[i] + (r_x[i] >>> i);
                    r_acc[i+1] <= r_acc[i] - T;
                end
            end
        end
    end

    assign rounded = r_acc[CORDIC_STAGES] + ROUND_HALF;
    assign o_angle = r_zero[CORDIC_STAGES] ? 16'h0000 : rounded[31:16];

endmodule

// ----- src/quaternion_to_euler.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_euler
// z-y-x euler angles from a q1.15 quaternion, as 16-bit binary angles
//
// channel   dir  tdata fields (lsb first)
// s_axis    in   quat_w, quat_x, quat_y, quat_z (16 bits each)
// m_axis    out  yaw_angle, pitch_angle, roll_angle (16 bits each)
//
// one item per cycle while m_axis is not stalled
// latency set by the 31-stage square root and the 16-stage cordic on pitch
// reset clears the valid bits only
// a stall on m_axis freezes the whole pipeline, nothing lost or repeated
// ----------------------------------------------------------------------------
module quaternion_to_euler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata    // yaw_angle, pitch_angle, roll_angle
);
    import qte_pkg::*;

    localparam int PIPE_DEPTH = 3 + ROOT_W + CORDIC_STAGES + 2;
    localparam int ANG_DLY    = 1 + ROOT_W;
    localparam int POLE_DLY   = CORDIC_STAGES + 1;

    logic en;
    logic r_vld [PIPE_DEPTH];

    logic signed [15:0] qw, qx, qy, qz;
    logic signed [31:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;
    logic signed [SUM_W-1:0] r_sinr, r_cosr, r_sinp, r_siny, r_cosy;

    logic [MAG_W-1:0]     mag;
    logic                 pole_pos, pole_neg;
    logic signed [SUM_W-1:0] abs_sinp;
    logic [2*MAG_W-1:0]   r_sq;
    t_ptag                r_ptag;

    logic [ROOT_W-1:0]    root;
    t_ptag                sq_tag;
    logic [15:0]          yaw_ang, roll_ang, pitch_ang;
    logic [15:0]          r_yaw_dly  [ANG_DLY];
    logic [15:0]          r_roll_dly [ANG_DLY];
    logic [1:0]           r_pole_dly [POLE_DLY];
    logic [15:0]          n_pitch;
    logic [47:0]          r_out;

    assign en = !r_vld[PIPE_DEPTH-1] || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_vld[PIPE_DEPTH-1];
    assign o_m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PIPE_DEPTH; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_s_axis_tvalid;
            for (int k = 1; k < PIPE_DEPTH; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    assign qw = i_s_axis_tdata[15:0];
    assign qx = i_s_axis_tdata[31:16];
    assign qy = i_s_axis_tdata[47:32];
    assign qz = i_s_axis_tdata[63:48];

    // products, q2.30
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wx <= qw * qx;
            r_yz <= qy * qz;
            r_xx <= qx * qx;
            r_yy <= qy * qy;
            r_wy <= qw * qy;
            r_zx <= qz * qx;
            r_wz <= qw * qz;
            r_xy <= qx * qy;
            r_zz <= qz * qz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sinr <= (SUM_W'(r_wx) + SUM_W'(r_yz)) <<< 1;
            r_cosr <= ONE_Q30 - ((SUM_W'(r_xx) + SUM_W'(r_yy)) <<< 1);
            r_sinp <= (SUM_W'(r_wy) - SUM_W'(r_zx)) <<< 1;
            r_siny <= (SUM_W'(r_wz) + SUM_W'(r_xy)) <<< 1;
            r_cosy <= ONE_Q30 - ((SUM_W'(r_yy) + SUM_W'(r_zz)) <<< 1);
        end
    end

    // pitch: pole test and square of the argument
    always_comb begin
        pole_pos = (r_sinp >= ONE_Q30);
        pole_neg = (r_sinp <= -ONE_Q30);
        abs_sinp = r_sinp[SUM_W-1] ? -r_sinp : r_sinp;
        mag      = (pole_pos || pole_neg) ? '0 : abs_sinp[MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq            <= mag * mag;
            r_ptag.pole_pos <= pole_pos;
            r_ptag.pole_neg <= pole_neg;
            r_ptag.sinp     <= r_sinp[SINP_W-1:0];
        end
    end

    qte_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (ONE_Q60 - RAD_W'(r_sq)),
        .i_tag  (r_ptag),
        .o_root (root),
        .o_tag  (sq_tag)
    );

    qte_cordic u_cordic_pitch (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (CW'(sq_tag.sinp)),
        .i_x     (CW'($signed({1'b0, root}))),
        .o_angle (pitch_ang)
    );

    qte_cordic u_cordic_yaw (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (CW'(r_siny)),
        .i_x     (CW'(r_cosy)),
        .o_angle (yaw_ang)
    );

    qte_cordic u_cordic_roll (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (CW'(r_sinr)),
        .i_x     (CW'(r_cosr)),
        .o_angle (roll_ang)
    );

    // line up yaw, roll and the pole flags with the pitch path
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_yaw_dly[0]  <= yaw_ang;
            r_roll_dly[0] <= roll_ang;
            for (int k = 1; k < ANG_DLY; k++) begin
                r_yaw_dly[k]  <= r_yaw_dly[k-1];
                r_roll_dly[k] <= r_roll_dly[k-1];
            end
            r_pole_dly[0] <= {sq_tag.pole_pos, sq_tag.pole_neg};
            for (int k = 1; k < POLE_DLY; k++) r_pole_dly[k] <= r_pole_dly[k-1];
        end
    end

    always_comb begin
        priority if (r_pole_dly[POLE_DLY-1][1]) begin
            n_pitch = PITCH_POS;
        end else if (r_pole_dly[POLE_DLY-1][0]) begin
            n_pitch = PITCH_NEG;
        end else begin
            n_pitch = pitch_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= {r_roll_dly[ANG_DLY-1], n_pitch, r_yaw_dly[ANG_DLY-1]};
        end
    end

endmodule

// ----- src/qte_checker.sv -----
// ----------------------------------------------------------------------------
// qte_checker
// port-level checks for quaternion_to_euler, bound to the top level
// ----------------------------------------------------------------------------
module qte_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata
);

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_axis_tvalid || i_m_axis_tready) |-> o_s_axis_tready)
        else $error("input stalled with output free");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled output item changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output item present after reset");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ($signed(o_m_axis_tdata[31:16]) <= 16'sd16384 &&
             $signed(o_m_axis_tdata[31:16]) >= -16'sd16384))
        else $error("pitch outside half pi");

endmodule

bind quaternion_to_euler qte_checker u_qte_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// ----- verif/quaternion_to_euler_tb.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_euler_tb
// self-checking bench: directed and random quaternions streamed with random
// bursts and output stalls, each angle triple checked against a local model
// ----------------------------------------------------------------------------
module quaternion_to_euler_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import qte_pkg::*;

    localparam int N_RANDOM  = 1700;
    localparam int WDOG_MAX  = 20000;
    localparam int TAIL_WAIT = 120;

    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
        logic signed [15:0] w;
    } t_quat;

    typedef struct packed {
        logic [15:0] roll;
        logic [15:0] pitch;
        logic [15:0] yaw;
    } t_euler;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    t_quat  quat_pending[$];
    t_euler angles_expected[$];
    int     n_errors = 0;
    int     idle_cycles = 0;
    bit     stim_done = 1'b0;
    bit     hold_sender = 1'b0;
    bit     long_stall_req = 1'b0;
    bit     s_fire = 1'b0;
    int     burst_left = 0;
    int     gap_left = 0;
    int     stall_left = 0;

    quaternion_to_euler i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [31:0] vector_angle(longint yv, longint xv);
        logic [31:0] acc;
        longint      dx, dy;
        acc = '0;
        if (xv == 0 && yv == 0) return '0;
        if (xv < 0) begin
            xv = -xv;
            yv = -yv;
            acc = ACC_PI;
        end
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            dx = floor_shift(yv, i);
            dy = floor_shift(xv, i);
            if (yv >= 0) begin
                xv = xv + dx;
                yv = yv - dy;
                acc = acc + ((i < 32) ? ATAN_TAB[i] : 32'h0);
            end else begin
                xv = xv - dx;
                yv = yv + dy;
                acc = acc - ((i < 32) ? ATAN_TAB[i] : 32'h0);
            end
        end
        return acc;
    endfunction

    function automatic logic [15:0] to_bam(logic [31:0] acc);
        logic [31:0] r;
        r = acc + ROUND_HALF;
        return r[31:16];
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_euler euler_of(t_quat q);
        t_euler          e;
        longint          w, x, y, z, one, sinr, cosr, sinp, siny, cosy;
        longint unsigned mag, c;
        w = q.w; x = q.x; y = q.y; z = q.z;
        one  = 64'sd1 << 30;
        sinr = 2 * (w * x + y * z);
        cosr = one - 2 * (x * x + y * y);
        sinp = 2 * (w * y - z * x);
        siny = 2 * (w * z + x * y);
        cosy = one - 2 * (y * y + z * z);
        if (sinp >= one) begin
            e.pitch = PITCH_POS;
        end else if (sinp <= -one) begin
            e.pitch = PITCH_NEG;
        end else begin
            mag = (sinp < 0) ? -sinp : sinp;
            c = root_floor((64'd1 << 60) - mag * mag);
            e.pitch = to_bam(vector_angle(sinp, longint'(c)));
        end
        e.yaw  = to_bam(vector_angle(siny, cosy));
        e.roll = to_bam(vector_angle(sinr, cosr));
        return e;
    endfunction

    task automatic add_quat(int w, int x, int y, int z);
        t_quat q;
        q.w = 16'(w); q.x = 16'(x); q.y = 16'(y); q.z = 16'(z);
        quat_pending.push_back(q);
    endtask

    function automatic int rnd_comp();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return -32768;
        if (k == 1) return 32767;
        if (k < 4) return $urandom_range(0, 64) - 32;
        return int'($signed(16'($urandom)));
    endfunction

    // driver: bursts and gaps, tvalid held until accepted
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_fire) begin
                angles_expected.push_back(euler_of(t_quat'(s_tdata)));
                void'(quat_pending.pop_front());
            end
            if (!s_tvalid || s_fire) begin
                if (burst_left == 0 && gap_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                if (gap_left > 0 && burst_left == 0) begin
                    gap_left = gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (!hold_sender && quat_pending.size() > 0) begin
                    if (burst_left > 0) burst_left = burst_left - 1;
                    s_tvalid <= 1'b1;
                    s_tdata <= quat_pending[0];
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern, with an optional long hold-off
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if (long_stall_req) begin
            long_stall_req = 1'b0;
            stall_left = 300;
            m_tready <= 1'b0;
        end else begin
            case ($urandom_range(0, 7))
                0: begin
                    stall_left = $urandom_range(1, 12);
                    m_tready <= 1'b0;
                end
                1: m_tready <= 1'b0;
                default: m_tready <= 1'b1;
            endcase
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_euler got, want;
        s_fire <= i_rst_n && s_tvalid && s_tready;
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles = idle_cycles + 1;
            if (m_tvalid && m_tready) begin
                got = t_euler'(m_tdata);
                if (angles_expected.size() == 0) begin
                    $error("unexpected item %h", m_tdata);
                    n_errors = n_errors + 1;
                end else begin
                    want = angles_expected.pop_front();
                    if (got.yaw !== want.yaw) begin
                        $error("yaw_angle: expected %h, got %h", want.yaw, got.yaw);
                        n_errors = n_errors + 1;
                    end
                    if (got.pitch !== want.pitch) begin
                        $error("pitch_angle: expected %h, got %h", want.pitch, got.pitch);
                        n_errors = n_errors + 1;
                    end
                    if (got.roll !== want.roll) begin
                        $error("roll_angle: expected %h, got %h", want.roll, got.roll);
                        n_errors = n_errors + 1;
                    end
                end
            end
            if (idle_cycles >= WDOG_MAX) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        // directed: identity, extremes, poles, zero vectors, angle of pi
        add_quat(32767, 0, 0, 0);
        add_quat(0, 0, 0, 0);
        add_quat(-32768, -32768, -32768, -32768);
        add_quat(32767, 32767, 32767, 32767);
        add_quat(-32768, 32767, -32768, 32767);
        add_quat(0, 32767, 0, 0);
        add_quat(0, 0, 0, 32767);
        add_quat(0, 0, 32767, 0);
        add_quat(23170, 0, 23170, 0);
        add_quat(23170, 0, -23170, 0);
        add_quat(23170, 23170, 23170, 23170);
        add_quat(23170, -23170, 23170, -23170);
        add_quat(23170, 0, 0, 23170);
        add_quat(23170, 23170, 0, 0);
        add_quat(16384, 16384, 16384, -16384);
        add_quat(0, -32768, 0, 0);
        add_quat(0, 0, 0, -32768);
        add_quat(23171, 0, 23171, 0);
        add_quat(-1, 1, -1, 1);
        add_quat(32767, 1, -1, 0);
        add_quat(0, 0, -32768, 0);
        add_quat(11585, 11585, 11585, 11585);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 400) long_stall_req = 1'b1;
            if (i == 900) begin
                wait (quat_pending.size() == 0);
                hold_sender = 1'b1;
                wait (quat_pending.size() == 0 && !s_tvalid && angles_expected.size() == 0);
                hold_sender = 1'b0;
            end
            add_quat(rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp());
        end
        wait (quat_pending.size() == 0 && !s_tvalid);
        wait (angles_expected.size() == 0);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (n_errors == 0 && angles_expected.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- quaternion_to_euler.f -----
src/qte_pkg.sv
src/qte_sqrt.sv
src/qte_cordic.sv
src/quaternion_to_euler.sv
src/qte_checker.sv
verif/quaternion_to_euler_tb.sv
